// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// File: rtl/core/knc_pkg.sv
`default_nettype none
package knc_pkg;

    localparam int DIST_W       = 32;
    localparam int RANK_W       = 7;
    localparam int DEF_MAX_RANK = 64;
    localparam int TAP_GROUP    = 8;

    localparam logic [RANK_W-1:0] RANK_RESET = 7'd5;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              last_of_row;
    } in_beat_t;

    typedef struct packed {
        logic [DIST_W-1:0] core_distance;
        logic              too_few_points;
    } out_beat_t;

    typedef struct packed {
        logic insert;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/knc_cell.sv
`default_nettype none
module knc_cell
    import knc_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire  cell_ctrl_t  ctrl_i,
    input  wire  [DIST_W-1:0] dist_i,
    input  wire               left_gt_i,
    input  wire  [DIST_W-1:0] left_value_i,
    input  wire               pick_i,
    output logic [DIST_W-1:0] value_o,
    output logic              gt_o,
    output logic [DIST_W-1:0] tap_o
);

    logic [DIST_W-1:0] value_reg;
    logic [DIST_W-1:0] value_next;
    logic [DIST_W-1:0] inserted;

    assign gt_o     = value_reg > dist_i;
    assign inserted = gt_o ? (left_gt_i ? left_value_i : dist_i) : value_reg;
    assign tap_o    = pick_i ? inserted : '0;
    assign value_o  = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl_i.insert) begin
            value_next = ctrl_i.clear ? DIST_MAX : inserted;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= DIST_MAX;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/knc_tap_reduce.sv
`default_nettype none
module knc_tap_reduce
    import knc_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  wire                             aclk,
    input  wire                             load_i,
    input  wire  [MAX_RANK-1:0][DIST_W-1:0] taps_i,
    output logic [DIST_W-1:0]               result_o
);

    localparam int NUM_GROUPS = (MAX_RANK + TAP_GROUP - 1) / TAP_GROUP;

    logic [NUM_GROUPS-1:0][DIST_W-1:0] group_reg;
    logic [NUM_GROUPS-1:0][DIST_W-1:0] group_next;

    always_comb begin
        group_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            for (int j = 0; j < TAP_GROUP; j++) begin
                if (g * TAP_GROUP + j < MAX_RANK) begin
                    group_next[g] = group_next[g] | taps_i[g * TAP_GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            group_reg <= group_next;
        end
    end

    always_comb begin
        result_o = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            result_o = result_o | group_reg[g];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/kth_nearest_core_distance_core.sv
// Throughput: one distance beat per cycle, the last beat of a row included, unless m_ready stalls a full pipeline.
// An accepted last beat sets stage_valid_reg; m_valid_reg takes it when m_valid is low or m_ready is high.
// Every cell of the insertion chain updates in the cycle its beat is accepted.
// Reset: chain cells go to the maximum distance, count to zero, rank to 5, pipeline empty.
`default_nettype none
`include "assert_macros.svh"
module kth_nearest_core_distance_core
    import knc_pkg::*;
#(
    parameter int MAX_RANK = DEF_MAX_RANK
)
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  in_beat_t    s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output out_beat_t         m_data,
    input  wire               cfg_wr_en,
    input  wire  [RANK_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_RANK + 1);

    logic [RANK_W-1:0] rank_reg;
    logic [CNT_W-1:0]  seen_count_reg;
    logic [CNT_W-1:0]  seen_count_next;
    logic              stage_valid_reg;
    logic              stage_err_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic              accept;
    logic              advance_out;
    logic              advance_stage;
    logic              row_err;
    cell_ctrl_t        ctrl;

    logic [MAX_RANK:0][DIST_W-1:0] chain_value;
    logic [MAX_RANK:0]             chain_gt;
    logic [MAX_RANK-1:0][DIST_W-1:0] taps;
    logic [DIST_W-1:0]             reduced;

    assign advance_out   = !m_valid_reg || m_ready;
    assign advance_stage = !stage_valid_reg || advance_out;
    assign s_ready       = advance_stage;
    assign accept        = s_valid && s_ready;
    assign ctrl.insert   = accept;
    assign ctrl.clear    = s_data.last_of_row;

    assign chain_value[0] = '0;
    assign chain_gt[0]    = 1'b0;

    for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
        knc_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl_i       (ctrl),
            .dist_i       (s_data.distance),
            .left_gt_i    (chain_gt[i]),
            .left_value_i (chain_value[i]),
            .pick_i       (32'(rank_reg) == 32'(i + 2)),
            .value_o      (chain_value[i+1]),
            .gt_o         (chain_gt[i+1]),
            .tap_o        (taps[i])
        );
    end

    knc_tap_reduce #(
        .MAX_RANK (MAX_RANK)
    ) u_reduce (
        .aclk     (aclk),
        .load_i   (advance_stage),
        .taps_i   (taps),
        .result_o (reduced)
    );

    always_comb begin
        seen_count_next = seen_count_reg;
        if (32'(seen_count_reg) < MAX_RANK) begin
            seen_count_next = seen_count_reg + 1'b1;
        end
    end

    always_comb begin
        row_err = 1'b0;
        if (rank_reg == '0 || 32'(rank_reg) > MAX_RANK) begin
            row_err = 1'b1;
        end else if (rank_reg != RANK_W'(1) &&
                     32'(seen_count_next) < 32'(rank_reg) - 32'd1) begin
            row_err = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg        <= RANK_RESET;
            seen_count_reg  <= '0;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rank_reg <= cfg_wr_data;
            end
            if (accept) begin
                seen_count_reg <= s_data.last_of_row ? '0 : seen_count_next;
            end
            if (advance_stage) begin
                stage_valid_reg <= accept && s_data.last_of_row;
            end
            if (advance_out) begin
                m_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_stage) begin
            stage_err_reg <= row_err;
        end
        if (advance_out) begin
            m_data_reg.core_distance  <= stage_err_reg ? '0 : reduced;
            m_data_reg.too_few_points <= stage_err_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_CLK(a_stall_full, aclk, aresetn,
                !s_ready |-> (stage_valid_reg && m_valid_reg),
                "input stalled while pipeline has room")
    `ASSERT_NEXT(a_last_loads, aclk, aresetn,
                 accept && s_data.last_of_row, stage_valid_reg,
                 "last beat did not reach the result stage")
    `ASSERT_NEXT(a_row_clear, aclk, aresetn,
                 accept && s_data.last_of_row, seen_count_reg == '0,
                 "count not cleared after last beat")

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_order
        `ASSERT_CLK(a_sorted, aclk, aresetn, chain_value[k] <= chain_value[k+1],
                    "insertion chain out of order")
    end

endmodule
`default_nettype wire
